// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, off while rst is high.
`define ATBQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("atbq assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define ATBQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   `ATBQ_ASSERT(label, clk, rst, (ante) |=> (cons))

`endif

// ===== rtl/core/atbq_pkg.sv =====
// Package for the adaptive two-bit quantizer/packer: widths, codes, types.
// No dependencies; imported by the interfaces, the testbench and every module but the checker.
package atbq_pkg;

   localparam int SAMPLE_W = 16;
   localparam int COUNT_W  = 20;
   localparam int SUM_W    = 50;
   localparam int ALU_W    = 32;
   localparam int THRESH_W = 16;
   localparam int STEP_W   = 6;
   localparam int SQRT_STEPS = ALU_W / 2;

   localparam logic [COUNT_W-1:0]  STAT_LIMIT = 20'd1000000;
   localparam logic [THRESH_W-1:0] THRESH_ONE = 16'd4096;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // fixed-mode decision levels, units of 2^-12
   localparam sample_type FIX_HALF = 16'sd1024;
   localparam sample_type FIX_LOW  = -16'sd3072;

   localparam logic [1:0] CODE_Q0 = 2'd0;
   localparam logic [1:0] CODE_Q1 = 2'd1;
   localparam logic [1:0] CODE_Q2 = 2'd2;
   localparam logic [1:0] CODE_Q3 = 2'd3;

   localparam logic [1:0] SLOT_LAST = 2'd3;

   typedef struct packed {
      logic       take;
      sample_type sample;
      logic       last;
      logic       adaptive;
   } item_cmd_type;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
   } alu_op_type;

   typedef struct packed {
      logic [ALU_W-1:0] diff;
      logic             ge;
   } alu_res_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ACCUM = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_ROOT  = 4'b1000
   } stat_state_type;

endpackage

// ===== rtl/core/atbq_channels.sv =====
// Channel interfaces: request, response and control-register write.
// Depends on atbq_pkg.
interface atbq_req_if import atbq_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type sample_value;
   logic       frame_end;
   modport source (output valid, output sample_value, output frame_end, input ready);
   modport sink   (input valid, input sample_value, input frame_end, output ready);
endinterface

interface atbq_rsp_if import atbq_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] packed_byte;
   logic       frame_last;
   modport source (output valid, output packed_byte, output frame_last, input ready);
   modport sink   (input valid, input packed_byte, input frame_last, output ready);
endinterface

interface atbq_csr_if import atbq_pkg::*; ();
   logic valid;
   logic ready;
   logic adaptive_enable;
   modport source (output valid, output adaptive_enable, input ready);
   modport sink   (input valid, input adaptive_enable, output ready);
endinterface

// ===== rtl/core/adaptive_two_bit_quantiser_packer.sv =====
// Top level of the adaptive two-bit quantizer and byte packer.
// Depends on atbq_pkg, atbq_channels, atbq_stats and atbq_packer.
//
// Usage:
//  - req_bus carries one sample beat: signed Q3.12 sample_value and
//    frame_end. csr_bus writes adaptive_enable (always ready); write it
//    only while no sample is in flight.
//  - rsp_bus carries one packed byte beat per four samples, or fewer at a
//    frame end (unused upper slots read zero); frame_last marks the close.
//  - Latency: a byte is on rsp_bus the cycle after the beat that completes
//    it. It sits in an output register, so the next sample can be taken
//    while it waits, as long as the receiver takes it in the same cycle.
//  - Throughput, set by the statistics sequencer:
//      fixed mode: one sample per cycle while the receiver keeps up;
//      adaptive mode: while samples are counted, each one is squared, then
//      accumulated before the next is taken;
//      adaptive frame end: plus 50 divide steps and 16 root steps on the
//      shared subtractor, then the new threshold applies.
//  - Reset (synchronous): empty packer, no byte pending, statistics
//    cleared, threshold 1.0, fixed mode.
//  - Receiver stall: the byte holds; req_bus.ready drops until it is taken.
module adaptive_two_bit_quantiser_packer import atbq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   atbq_req_if.sink   req_bus,
   atbq_rsp_if.source rsp_bus,
   atbq_csr_if.sink   csr_bus
);

   logic                adaptive_ff, adaptive_in;
   item_cmd_type        cmd;
   logic                stat_busy;
   logic                out_free;
   logic [THRESH_W-1:0] threshold;

   // control register: one bit, never stalls
   assign csr_bus.ready = 1'b1;
   assign adaptive_in   = (csr_bus.valid) ? csr_bus.adaptive_enable : adaptive_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         adaptive_ff <= 1'b0;
      end else begin
         adaptive_ff <= adaptive_in;
      end
   end

   // take a sample only when the sequencer is idle and the byte slot is free
   assign req_bus.ready = !stat_busy && out_free;

   assign cmd.take     = req_bus.valid && req_bus.ready;
   assign cmd.sample   = req_bus.sample_value;
   assign cmd.last     = req_bus.frame_end;
   assign cmd.adaptive = adaptive_ff;

   atbq_stats u_stats (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .busy      (stat_busy),
      .threshold (threshold)
   );

   // quantizes against the threshold held before this sample's frame end
   atbq_packer u_packer (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .threshold (threshold),
      .out_ready (rsp_bus.ready),
      .out_valid (rsp_bus.valid),
      .out_byte  (rsp_bus.packed_byte),
      .out_last  (rsp_bus.frame_last),
      .out_free  (out_free)
   );

endmodule

// ===== rtl/core/atbq_sub_unit.sv =====
// Shared subtract/compare unit used by the divide and square-root steps.
// Depends on atbq_pkg.
module atbq_sub_unit import atbq_pkg::*; (
   input  alu_op_type  op,
   output alu_res_type res
);

   logic [ALU_W:0] wide;

   assign wide     = {1'b0, op.a} - {1'b0, op.b};
   assign res.diff = wide[ALU_W-1:0];
   assign res.ge   = ~wide[ALU_W];

endmodule

// ===== rtl/core/atbq_stats.sv =====
// Running statistics and threshold: square accumulation, restoring divide
// and digit-by-digit square root, the last two on one shared subtractor.
// Depends on atbq_pkg and atbq_sub_unit.
module atbq_stats import atbq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  item_cmd_type        cmd,
   output logic                busy,
   output logic [THRESH_W-1:0] threshold
);

   stat_state_type      state_ff, state_in;
   logic [ALU_W-1:0]    sq_ff, sq_in;
   logic                last_ff, last_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic [SUM_W-1:0]    work_ff, work_in;
   logic [ALU_W-1:0]    rem_ff, rem_in;
   logic [THRESH_W-1:0] root_ff, root_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   logic signed [2*SAMPLE_W-1:0] square;
   logic [ALU_W-1:0]             div_part, root_part, trial;
   alu_op_type                   op;
   alu_res_type                  res;

   assign square    = cmd.sample * cmd.sample;
   assign div_part  = {rem_ff[ALU_W-2:0], work_ff[SUM_W-1]};
   assign root_part = {rem_ff[ALU_W-3:0], work_ff[ALU_W-1:ALU_W-2]};
   assign trial     = ALU_W'({root_ff, 2'b01});

   always_comb begin
      if (state_ff == ST_ROOT) begin
         op.a = root_part;
         op.b = trial;
      end else begin
         op.a = div_part;
         op.b = ALU_W'(count_ff);
      end
   end

   atbq_sub_unit u_sub (
      .op  (op),
      .res (res)
   );

   always_comb begin
      state_in  = state_ff;
      sq_in     = sq_ff;
      last_in   = last_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      thresh_in = thresh_ff;
      work_in   = work_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      step_in   = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.take) begin
               sq_in   = ALU_W'($unsigned(square));
               last_in = cmd.last;
               if (cmd.adaptive && (count_ff < STAT_LIMIT)) begin
                  state_in = ST_ACCUM;
               end else if (cmd.last && cmd.adaptive && (count_ff != '0)) begin
                  state_in = ST_DIV;
                  work_in  = sum_ff;
                  rem_in   = '0;
                  step_in  = '0;
               end
            end
         end
         ST_ACCUM: begin
            sum_in   = sum_ff + SUM_W'(sq_ff);
            count_in = count_ff + 1'b1;
            if (last_ff) begin
               state_in = ST_DIV;
               work_in  = sum_in;
               rem_in   = '0;
               step_in  = '0;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            rem_in  = res.ge ? res.diff : op.a;
            work_in = {work_ff[SUM_W-2:0], res.ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               // quotient now sits in work; it never exceeds 2^30
               state_in = ST_ROOT;
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
            end
         end
         ST_ROOT: begin
            rem_in  = res.ge ? res.diff : op.a;
            root_in = {root_ff[THRESH_W-2:0], res.ge};
            work_in = {work_ff[SUM_W-3:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               thresh_in = root_in;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         sum_ff    <= '0;
         count_ff  <= '0;
         thresh_ff <= THRESH_ONE;
      end else begin
         state_ff  <= state_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         thresh_ff <= thresh_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff   <= sq_in;
      last_ff <= last_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      step_ff <= step_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign threshold = thresh_ff;

endmodule

// ===== rtl/core/atbq_packer.sv =====
// Two-bit quantizer, four-code byte packer and response output register.
// Depends on atbq_pkg.
module atbq_packer import atbq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  item_cmd_type        cmd,
   input  logic [THRESH_W-1:0] threshold,
   input  logic                out_ready,
   output logic                out_valid,
   output logic [7:0]          out_byte,
   output logic                out_last,
   output logic                out_free
);

   logic [5:0] buf_ff, buf_in;
   logic [1:0] slot_ff, slot_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;

   logic signed [SAMPLE_W+3:0] s2, t1, t3;
   logic [1:0]                 q;
   logic [7:0]                 q_shift;
   logic                       emit;

   assign s2 = {{3{cmd.sample[SAMPLE_W-1]}}, cmd.sample, 1'b0};
   assign t1 = {4'b0000, threshold};
   assign t3 = t1 + (t1 <<< 1);

   always_comb begin
      if (cmd.adaptive) begin
         priority if (s2 > t1)   q = CODE_Q3;
         else if (s2 >= -t1)     q = CODE_Q2;
         else if (s2 > -t3)      q = CODE_Q1;
         else                    q = CODE_Q0;
      end else begin
         priority if (cmd.sample > FIX_HALF)    q = CODE_Q3;
         else if (cmd.sample >= -FIX_HALF)      q = CODE_Q2;
         else if (cmd.sample > FIX_LOW)         q = CODE_Q1;
         else                                   q = CODE_Q0;
      end
   end

   assign q_shift = 8'(q) << {slot_ff, 1'b0};
   assign emit    = cmd.take && ((slot_ff == SLOT_LAST) || cmd.last);

   always_comb begin
      buf_in   = buf_ff;
      slot_in  = slot_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !out_ready;
      if (emit) begin
         byte_in  = {2'b00, buf_ff} | q_shift;
         last_in  = cmd.last;
         valid_in = 1'b1;
         buf_in   = '0;
         slot_in  = '0;
      end else if (cmd.take) begin
         buf_in  = buf_ff | q_shift[5:0];
         slot_in = slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff   <= '0;
         slot_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         buf_ff   <= buf_in;
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;
   assign out_free  = !valid_ff || out_ready;

endmodule

// ===== rtl/core/atbq_checker.sv =====
// Port-level checks for the quantizer/packer, bound to the top level.
// Depends on assert_macros.svh and adaptive_two_bit_quantiser_packer.
`include "assert_macros.svh"

module atbq_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_frame_end,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_frame_last
);

   // nothing pending right after reset
   `ATBQ_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

   // a stalled byte stays offered
   `ATBQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // no new sample while the byte register is blocked
   `ATBQ_ASSERT(a_no_take_blocked, clock, reset,
      (rsp_valid && !rsp_ready) |-> !req_ready)

   // a frame end flushes a closing byte in the cycle after it is taken
   `ATBQ_ASSERT_NEXT(a_frame_flush, clock, reset,
      req_valid && req_ready && req_frame_end, rsp_valid && rsp_frame_last)

endmodule

bind adaptive_two_bit_quantiser_packer atbq_checker u_atbq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .req_frame_end  (req_bus.frame_end),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_frame_last (rsp_bus.frame_last)
);

// ===== verif/adaptive_two_bit_quantiser_packer_tb.sv =====
`timescale 1ns / 100ps
// Testbench for adaptive_two_bit_quantiser_packer: a directed table, then random frames in
// both modes; each byte is checked against its typed row or a quantizer/packer model here.
// Depends on atbq_pkg, the atbq_channels interfaces and the block's RTL.
module adaptive_two_bit_quantiser_packer_tb;
   import atbq_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before the run is declared hung
   localparam int SETTLE_CYCLES  = 100;   // long enough for the frame-end divide and root steps
   localparam int MAX_GAP        = 12;
   localparam int MAX_REPORTS    = 10;
   localparam int PHASE_ITEMS    = 215;
   localparam int NUM_PHASES     = 6;

   // fixed-mode decision levels, units of 2^-12
   localparam longint FIX_EDGE  = 1024;
   localparam longint FIX_FLOOR = -3072;
   localparam longint FIX_LEVELS [3] = '{1024, -1024, -3072};

   // mode per random phase (1 -> 1 rewrites the same value); calm phases never idle
   localparam logic PHASE_MODES [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
   localparam bit   PHASE_CALM  [NUM_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

   typedef enum logic {ROW_SAMPLE, ROW_CSR} row_kind_type;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       frame_last;
   } byte_beat_type;

   typedef struct {
      row_kind_type kind;
      int           value;      // sample, or adaptive_enable on a CSR row
      logic         frame_end;
      bit           typed;      // expected byte given in the row
      logic [7:0]   exp_byte;
      logic         exp_last;
   } stim_row_type;

   // Directed table. Typed bytes are read straight off the decision levels:
   // fixed-mode edges and extremes, the first adaptive frame (threshold still 1.0),
   // then a zero threshold built from an all-zero frame. The rest goes to the model.
   stim_row_type dir_rows [27] = '{
      '{ROW_CSR,         0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE,   1025, 1'b0, 1'b0, 8'h00, 1'b0},   // just above +0.25: q3
      '{ROW_SAMPLE,  -1024, 1'b0, 1'b0, 8'h00, 1'b0},   // on -0.25: q2
      '{ROW_SAMPLE,  -3071, 1'b0, 1'b0, 8'h00, 1'b0},   // just above -0.75: q1
      '{ROW_SAMPLE,  -3072, 1'b0, 1'b1, 8'h1B, 1'b0},   // on -0.75: q0, full byte
      '{ROW_SAMPLE,   1024, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE,  -1025, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE,  32767, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE, -32768, 1'b0, 1'b1, 8'h36, 1'b0},
      '{ROW_SAMPLE,  32767, 1'b1, 1'b1, 8'h03, 1'b1},   // one-code frame, padded
      '{ROW_SAMPLE,      0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE, -32768, 1'b1, 1'b1, 8'h02, 1'b1},
      '{ROW_CSR,         1, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE,      0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE,      0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE,      0, 1'b1, 1'b1, 8'h2A, 1'b1},   // rms of zeros: threshold 0
      '{ROW_SAMPLE,      1, 1'b0, 1'b0, 8'h00, 1'b0},   // zero threshold: positive q3
      '{ROW_SAMPLE,      0, 1'b0, 1'b0, 8'h00, 1'b0},   // zero q2
      '{ROW_SAMPLE,     -1, 1'b0, 1'b0, 8'h00, 1'b0},   // negative q0
      '{ROW_SAMPLE,  32767, 1'b0, 1'b1, 8'hCB, 1'b0},
      '{ROW_SAMPLE, -32768, 1'b1, 1'b1, 8'h00, 1'b1},
      '{ROW_SAMPLE,   2048, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE,  -2048, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE,  -6144, 1'b1, 1'b0, 8'h00, 1'b0},
      '{ROW_SAMPLE,    100, 1'b0, 1'b0, 8'h00, 1'b0},
      '{ROW_CSR,         0, 1'b0, 1'b0, 8'h00, 1'b0},   // mode change mid-frame
      '{ROW_SAMPLE,   1025, 1'b1, 1'b0, 8'h00, 1'b0}
   };

   logic clock = 1'b0;
   logic reset;

   atbq_req_if req_if ();
   atbq_rsp_if rsp_if ();
   atbq_csr_if csr_if ();

   adaptive_two_bit_quantiser_packer u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Quantizer/packer model state, updated at every accepted beat.
   logic        mode_adaptive;
   logic [5:0]  held_codes;
   logic [1:0]  held_slots;
   int unsigned energy_count;
   logic [63:0] energy_sum;     // sum of s*s, units of 2^-24
   logic [63:0] rms_thresh;     // Q4.12

   byte_beat_type expected_bytes [$];
   int            mismatches  = 0;
   int            quiet_cycles = 0;
   bit            no_idle     = 1'b0;

   // Truncated square root, one result bit per pass from the top.
   function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
      logic [63:0] root;
      logic [63:0] cand;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         if (cand * cand <= x)
            root = cand;
      end
      return root;
   endfunction

   function automatic logic [1:0] level_code(input sample_type s);
      longint sv;
      longint t;
      sv = longint'(s);
      if (!mode_adaptive) begin
         if (sv > FIX_EDGE)   return CODE_Q3;
         if (sv >= -FIX_EDGE) return CODE_Q2;
         if (sv > FIX_FLOOR)  return CODE_Q1;
         return CODE_Q0;
      end
      // adaptive: levels at +-T/2 and -3T/2, compared as 2s against T
      t = longint'(rms_thresh);
      if (2 * sv > t)      return CODE_Q3;
      if (2 * sv >= -t)    return CODE_Q2;
      if (2 * sv > -3 * t) return CODE_Q1;
      return CODE_Q0;
   endfunction

   // One accepted sample beat; returns 1 when it closes a byte.
   function automatic bit quantise_and_pack(input sample_type s, input logic fe,
                                            output byte_beat_type beat);
      longint     sv;
      logic [1:0] code;
      sv = longint'(s);
      if (mode_adaptive && energy_count < STAT_LIMIT) begin
         energy_count++;
         energy_sum += 64'(sv * sv);
      end
      // the code uses the threshold held before this beat
      code = level_code(s);
      if (fe && mode_adaptive && energy_count > 0)
         rms_thresh = floor_sqrt(energy_sum / 64'(energy_count));
      beat = '0;
      if (held_slots == SLOT_LAST || fe) begin
         beat.packed_byte = {2'b00, held_codes} | (8'(code) << (2 * held_slots));
         beat.frame_last  = fe;
         held_codes = '0;
         held_slots = '0;
         return 1'b1;
      end
      held_codes = held_codes | (6'(code) << (2 * held_slots));
      held_slots = held_slots + 2'd1;
      return 1'b0;
   endfunction

   function automatic int draw_gap();
      if (no_idle || $urandom_range(3) == 0)
         return 0;
      return $urandom_range(MAX_GAP);
   endfunction

   // Mix of extremes, fixed levels, levels around the live threshold (ties
   // when it is even), small values and the full range.
   function automatic sample_type random_sample();
      longint t;
      longint v;
      t = longint'(rms_thresh);
      case ($urandom_range(7))
         0: v = $urandom_range(1) ? 64'sd32767 : -64'sd32768;
         1: v = FIX_LEVELS[$urandom_range(2)] + int'($urandom_range(2)) - 1;
         2, 3: begin
            case ($urandom_range(2))
               0: v = t >>> 1;
               1: v = -(t >>> 1);
               default: v = -((3 * t) >>> 1);
            endcase
            v = v + int'($urandom_range(2)) - 1;
         end
         4, 5: v = longint'($urandom_range(8191)) - 4096;
         default: v = longint'($urandom_range(65535)) - 32768;
      endcase
      if (v > 32767)  v = 32767;
      if (v < -32768) v = -32768;
      return sample_type'(v);
   endfunction

   task automatic flag_error(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("[%0t] %s", $time, msg);
   endtask

   // Sender: optional gap, then hold the beat until accepted. valid stays high
   // into the next beat when there is no gap.
   task automatic send_sample(input sample_type s, input logic fe, input bit typed,
                              input byte_beat_type typed_beat);
      int            gap;
      byte_beat_type beat;
      gap = draw_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.sample_value <= s;
      req_if.frame_end    <= fe;
      do @(posedge clock); while (!req_if.ready);
      if (quantise_and_pack(s, fe, beat))
         expected_bytes = {expected_bytes, (typed ? typed_beat : beat)};
   endtask

   // Stop sending until every byte is back, then let the block settle.
   task automatic wait_drained(input int settle);
      req_if.valid <= 1'b0;
      do @(posedge clock); while (expected_bytes.size() != 0);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_mode(input logic on);
      wait_drained(SETTLE_CYCLES);
      csr_if.valid           <= 1'b1;
      csr_if.adaptive_enable <= on;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      mode_adaptive = on;
   endtask

   // Receiver: random stall per beat, then compare with the oldest expected byte.
   initial begin : rsp_sink
      int            stall;
      byte_beat_type want;
      byte_beat_type got;
      rsp_if.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         got = {rsp_if.packed_byte, rsp_if.frame_last};
         if (expected_bytes.size() == 0) begin
            flag_error($sformatf("unexpected beat: byte %02h last %b",
                                 got.packed_byte, got.frame_last));
         end else begin
            want = expected_bytes.pop_front();
            if (got.packed_byte !== want.packed_byte || got.frame_last !== want.frame_last)
               flag_error($sformatf("byte mismatch: expected %02h last %b, got %02h last %b",
                                    want.packed_byte, want.frame_last,
                                    got.packed_byte, got.frame_last));
         end
      end
   end

   // Watchdog: any accepted beat on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no beat for %0d cycles", quiet_cycles);
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      stim_row_type  row;
      byte_beat_type typed_beat;
      logic          fe;
      int            frame_left;
      reset                  <= 1'b1;
      req_if.valid           <= 1'b0;
      req_if.sample_value    <= '0;
      req_if.frame_end       <= 1'b0;
      csr_if.valid           <= 1'b0;
      csr_if.adaptive_enable <= 1'b0;
      mode_adaptive = 1'b0;
      held_codes    = '0;
      held_slots    = '0;
      energy_count  = 0;
      energy_sum    = '0;
      rms_thresh    = 64'(THRESH_ONE);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.kind == ROW_CSR) begin
            write_mode(row.value[0]);
         end else begin
            typed_beat = {row.exp_byte, row.exp_last};
            send_sample(sample_type'(row.value), row.frame_end, row.typed, typed_beat);
         end
      end

      // Random frames, mostly 1..12 beats, a few long ones; the odd stray
      // frame_end cuts a frame short or lets it run on. Frames run across mode changes.
      frame_left = 0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_mode(PHASE_MODES[p]);
         no_idle = PHASE_CALM[p];
         repeat (PHASE_ITEMS) begin
            if (frame_left == 0)
               frame_left = ($urandom_range(7) == 0) ? $urandom_range(40, 1)
                                                     : $urandom_range(12, 1);
            fe = (frame_left == 1);
            if ($urandom_range(15) == 0)
               fe = 1'($urandom_range(1));
            frame_left = fe ? 0 : frame_left - 1;
            send_sample(random_sample(), fe, 1'b0, '0);
            if ($urandom_range(99) == 0)
               wait_drained(0);
         end
      end

      wait_drained(SETTLE_CYCLES);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
